// ===== rtl/core/sparse_polynomial_term_store_core_defines.svh =====
// Assertion macros for the sparse polynomial term store core.
// Used by spts_datapath, the RTL file that asserts; empty bodies under SYNTHESIS.
`ifndef SPARSE_POLYNOMIAL_TERM_STORE_CORE_DEFINES_SVH
`define SPARSE_POLYNOMIAL_TERM_STORE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SPTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("spts: invariant violated");
`define SPTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("spts: implication violated");
`define SPTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("spts: next-cycle check violated");
`else
`define SPTS_ASSERT(lbl, clk, rstn, prop)
`define SPTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SPTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/spts_pkg.sv =====
// Package of the sparse polynomial term store core: sizes, codes, control types.
// No dependencies.
package spts_pkg;

  localparam int unsigned MaxTerms = 16;
  localparam int unsigned AddrW    = $clog2(MaxTerms);
  localparam int unsigned CntW     = $clog2(MaxTerms + 1);
  localparam int unsigned CoeffW   = 32;
  localparam int unsigned ExpW     = 6;
  localparam int unsigned EntryW   = CoeffW + ExpW;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_MERGED    = 2'd1,
    ST_FULL      = 2'd2,
    ST_EVALUATED = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_EVAL = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC,
    IDX_COUNT
  } idx_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_MERGE,
    WR_SHIFT,
    WR_INSERT
  } wr_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CK,
    S_INS_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_EVAL_RD,
    S_EVAL_LD,
    S_EVAL_POW,
    S_EVAL_MUL,
    S_EVAL_ACC,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic    load_item;
    idx_op_e idx_op;
    logic    rd_prev;
    wr_op_e  wr_op;
    logic    save_pos;
    logic    pow_load;
    logic    pow_step;
    logic    mul_load;
    logic    acc_add;
    logic    set_status;
    status_e status_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_eval;
    logic idx_at_count;
    logic idx_at_pos;
    logic full;
    logic rd_exp_eq;
    logic rd_exp_gt;
    logic pow_done;
  } sts_t;

endpackage

// ===== rtl/core/spts_in_if.sv =====
// Command channel of the sparse polynomial term store core.
// Depends on spts_pkg.
interface spts_in_if import spts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [CoeffW-1:0] term_coeff_in;
  logic        [ExpW-1:0]   term_exp_in;
  logic signed [CoeffW-1:0] eval_point;

  modport source (
    output valid, command, term_coeff_in, term_exp_in, eval_point,
    input  ready
  );
  modport sink (
    input  valid, command, term_coeff_in, term_exp_in, eval_point,
    output ready
  );
endinterface

// ===== rtl/core/spts_out_if.sv =====
// Result channel of the sparse polynomial term store core.
// Depends on spts_pkg.
interface spts_out_if import spts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [1:0]        status;
  logic signed [CoeffW-1:0] poly_value;

  modport source (
    output valid, status, poly_value,
    input  ready
  );
  modport sink (
    input  valid, status, poly_value,
    output ready
  );
endinterface

// ===== rtl/core/spts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/spts_datapath.sv =====
// Datapath of the sparse polynomial term store core: term table, indexes, power and
// accumulate unit, result register. Depends on spts_pkg, spts_ram and the defines header.
`include "sparse_polynomial_term_store_core_defines.svh"
module spts_datapath import spts_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     command_i,
  input  logic signed [CoeffW-1:0] term_coeff_i,
  input  logic        [ExpW-1:0]   term_exp_i,
  input  logic signed [CoeffW-1:0] eval_point_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  output status_e                  status_o,
  output logic signed [CoeffW-1:0] poly_value_o
);

  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   idx_m1;
  logic [CntW-1:0]   pos_q;

  command_e          cmd_q;
  logic [CoeffW-1:0] coeff_q;
  logic [ExpW-1:0]   expo_q;
  logic [CoeffW-1:0] point_q;

  logic [CoeffW-1:0] pow_acc_q;
  logic [CoeffW-1:0] pow_base_q;
  logic [ExpW-1:0]   pow_e_q;
  logic [CoeffW-1:0] term_q;
  logic [CoeffW-1:0] prod_q;
  logic [CoeffW-1:0] sum_q;
  status_e           res_status_q;
  status_e           out_status_q;
  logic [CoeffW-1:0] out_value_q;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [AddrW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;
  logic [ExpW-1:0]   rd_exp;
  logic [CoeffW-1:0] rd_coeff;

  assign rd_exp   = ram_rdata[EntryW-1:CoeffW];
  assign rd_coeff = ram_rdata[CoeffW-1:0];
  assign idx_m1   = idx_q - CntW'(1);

  always_comb begin
    idx_d = idx_q;
    unique case (cmd_i.idx_op)
      IDX_HOLD:  idx_d = idx_q;
      IDX_ZERO:  idx_d = '0;
      IDX_INC:   idx_d = idx_q + CntW'(1);
      IDX_DEC:   idx_d = idx_m1;
      IDX_COUNT: idx_d = count_q;
      default:   idx_d = idx_q;
    endcase
  end

  assign count_d = (cmd_i.wr_op == WR_INSERT) ? count_q + CntW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  assign ram_raddr = cmd_i.rd_prev ? idx_m1[AddrW-1:0] : idx_q[AddrW-1:0];
  assign ram_we    = (cmd_i.wr_op != WR_NONE);
  assign ram_waddr = (cmd_i.wr_op == WR_INSERT) ? pos_q[AddrW-1:0] : idx_q[AddrW-1:0];

  always_comb begin
    ram_wdata = ram_rdata;
    case (cmd_i.wr_op)
      WR_MERGE:  ram_wdata = {rd_exp, rd_coeff + coeff_q};
      WR_INSERT: ram_wdata = {expo_q, coeff_q};
      default:   ram_wdata = ram_rdata;
    endcase
  end

  spts_ram #(
    .Width (EntryW),
    .Depth (MaxTerms)
  ) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q   <= command_e'(command_i);
      coeff_q <= term_coeff_i;
      expo_q  <= term_exp_i;
      point_q <= eval_point_i;
      sum_q   <= '0;
    end else if (cmd_i.acc_add) begin
      sum_q <= sum_q + prod_q;
    end
    if (cmd_i.save_pos) begin
      pos_q <= idx_q;
    end
    if (cmd_i.pow_load) begin
      pow_acc_q  <= CoeffW'(1);
      pow_base_q <= point_q;
      pow_e_q    <= rd_exp;
      term_q     <= rd_coeff;
    end else if (cmd_i.pow_step) begin
      if (pow_e_q[0]) begin
        pow_acc_q <= pow_acc_q * pow_base_q;
      end
      pow_base_q <= pow_base_q * pow_base_q;
      pow_e_q    <= pow_e_q >> 1;
    end
    if (cmd_i.mul_load) begin
      prod_q <= term_q * pow_acc_q;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status_code;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= sum_q;
    end
  end

  assign sts_o.is_eval      = (cmd_q == CMD_EVAL);
  assign sts_o.idx_at_count = (idx_q == count_q);
  assign sts_o.idx_at_pos   = (idx_q == pos_q);
  assign sts_o.full         = (count_q == CntW'(MaxTerms));
  assign sts_o.rd_exp_eq    = (rd_exp == expo_q);
  assign sts_o.rd_exp_gt    = (rd_exp > expo_q);
  assign sts_o.pow_done     = (pow_e_q == '0);

  assign status_o     = out_status_q;
  assign poly_value_o = out_value_q;

  `SPTS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(MaxTerms))
  `SPTS_ASSERT(a_idx_bound, clk_i, rst_ni, idx_q <= count_q)
  `SPTS_ASSERT_IMPL(a_insert_not_full, clk_i, rst_ni,
                    cmd_i.wr_op == WR_INSERT, count_q < CntW'(MaxTerms))
  `SPTS_ASSERT_NEXT(a_count_step, clk_i, rst_ni,
                    cmd_i.wr_op == WR_INSERT, count_q == $past(count_q) + CntW'(1))
  `SPTS_ASSERT_IMPL(a_add_value_zero, clk_i, rst_ni,
                    cmd_i.out_load && res_status_q != ST_EVALUATED, sum_q == '0)

endmodule

// ===== rtl/core/spts_ctrl.sv =====
// Controller of the sparse polynomial term store core: sequences scan, shift,
// evaluate and result hand-off. Depends on spts_pkg.
module spts_ctrl import spts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cmd_o.idx_op    = IDX_ZERO;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = sts_i.is_eval ? S_EVAL_RD : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (sts_i.idx_at_count) begin
          cmd_o.save_pos = 1'b1;
          state_d        = S_INS_CHK;
        end else begin
          state_d = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (sts_i.rd_exp_eq) begin
          cmd_o.wr_op       = WR_MERGE;
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = ST_MERGED;
          state_d           = S_DONE;
        end else if (sts_i.rd_exp_gt) begin
          cmd_o.save_pos = 1'b1;
          state_d        = S_INS_CHK;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_SCAN_RD;
        end
      end
      S_INS_CHK: begin
        if (sts_i.full) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = ST_FULL;
          state_d           = S_DONE;
        end else begin
          cmd_o.idx_op = IDX_COUNT;
          state_d      = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts_i.idx_at_pos) begin
          cmd_o.wr_op       = WR_INSERT;
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = ST_INSERTED;
          state_d           = S_DONE;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_op  = WR_SHIFT;
        cmd_o.idx_op = IDX_DEC;
        state_d      = S_SHIFT_RD;
      end
      S_EVAL_RD: begin
        if (sts_i.idx_at_count) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = ST_EVALUATED;
          state_d           = S_DONE;
        end else begin
          state_d = S_EVAL_LD;
        end
      end
      S_EVAL_LD: begin
        cmd_o.pow_load = 1'b1;
        state_d        = S_EVAL_POW;
      end
      S_EVAL_POW: begin
        if (sts_i.pow_done) begin
          state_d = S_EVAL_MUL;
        end else begin
          cmd_o.pow_step = 1'b1;
        end
      end
      S_EVAL_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = S_EVAL_ACC;
      end
      S_EVAL_ACC: begin
        cmd_o.acc_add = 1'b1;
        cmd_o.idx_op  = IDX_INC;
        state_d       = S_EVAL_RD;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/sparse_polynomial_term_store_core.sv =====
// Top level of the sparse polynomial term store core.
// Depends on spts_pkg, spts_in_if, spts_out_if, spts_ctrl and spts_datapath.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   command, term_coeff_in, term_exp_in, eval_point
//   out_o    out  valid/ready   status, poly_value
//
// One transaction in flight; add compares the new exponent with the stored entries in order:
// on an equal exponent it merges the coefficients, else it inserts the term, shifting the
// entries above it up, or drops it with status full when the table is full.
// Evaluate sums the terms at the point with the shared square-and-multiply unit.
// Reset clears the count.
// A result waiting in the output register holds the next one in S_DONE, not the input.
module sparse_polynomial_term_store_core import spts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  spts_in_if.sink   in_i,
  spts_out_if.source out_o
);

  cmd_t    cmd;
  sts_t    sts;
  status_e status;

  spts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spts_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (in_i.command),
    .term_coeff_i (in_i.term_coeff_in),
    .term_exp_i   (in_i.term_exp_in),
    .eval_point_i (in_i.eval_point),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .status_o     (status),
    .poly_value_o (out_o.poly_value)
  );

  assign out_o.status = status;

endmodule
